// ===== rtl/core/dsd_pkg.sv =====
`default_nettype none
package dsd_pkg;

  localparam int SETS          = 2048;
  localparam int WAYS          = 16;
  localparam int LEADER_GROUPS = 64;
  localparam int SEL_W         = 10;

  localparam int STAMP_W    = 64;
  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = $clog2(WAYS);
  localparam int GROUP_SIZE = SETS / LEADER_GROUPS;
  localparam int OFF_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int ROW_W      = WAYS * STAMP_W;
  localparam int PERIOD_W   = 10;
  localparam int FILL_W     = 10;

  // first min level reduces groups of this many ways
  localparam int L1_GRP = 4;
  localparam int L1_N   = (WAYS + L1_GRP - 1) / L1_GRP;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(20);
  localparam logic [SEL_W-1:0]    SEL_MID    = SEL_W'(1) << (SEL_W - 1);
  localparam logic [SEL_W-1:0]    SEL_MAX    = {SEL_W{1'b1}};

  localparam logic REQ_VICTIM = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ROLE_LRU,
    ROLE_BIP,
    ROLE_FOLLOW
  } role_t;

  typedef struct packed {
    logic               req_type;
    logic [SET_W-1:0]   set_index;
    logic [WAY_W-1:0]   way;
    logic               hit;
    logic [STAMP_W-1:0] now;
    role_t              role;
  } item_t;

  // back-end status toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  function automatic role_t set_role(input logic [SET_W-1:0] set_idx);
    logic [SET_W-1:0] grp;
    logic [SET_W-1:0] off;
    logic [SET_W-1:0] comp;
    logic [SET_W-1:0] mask;
    mask = SET_W'(GROUP_SIZE - 1);
    grp  = (GROUP_SIZE > 1) ? (set_idx >> OFF_W) : set_idx;
    off  = set_idx & mask;
    comp = (~off) & mask;
    if (grp == off) begin
      return ROLE_LRU;
    end else if (grp == comp) begin
      return ROLE_BIP;
    end
    return ROLE_FOLLOW;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dsd_front.sv =====
`default_nettype none
module dsd_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_req_type,
  input  wire logic [dsd_pkg::SET_W-1:0] in_set_index,
  input  wire logic [dsd_pkg::WAY_W-1:0] in_way,
  input  wire logic                      in_hit,
  input  wire logic [dsd_pkg::STAMP_W-1:0] in_now,
  input  wire dsd_pkg::back_stat_t       stat,
  output logic                           q_valid,
  output dsd_pkg::item_t                 q_item
);

  dsd_pkg::item_t q_mem_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  dsd_pkg::item_t new_item;

  assign in_stall = (cnt_r == 2'd2) || stat.clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];

  always_comb begin
    new_item.req_type  = in_req_type;
    new_item.set_index = in_set_index;
    new_item.way       = in_way;
    new_item.hit       = in_hit;
    new_item.now       = in_now;
    new_item.role      = dsd_pkg::set_role(in_set_index);
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = stat.pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(stat.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dsd_back.sv =====
`default_nettype none
module dsd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire dsd_pkg::item_t                q_item,
  output dsd_pkg::back_stat_t                stat,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dsd_pkg::PERIOD_W-1:0]  cfg_bip_period,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dsd_pkg::WAY_W-1:0]          out_victim_way,
  output logic [dsd_pkg::SEL_W-1:0]          out_selector_value
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MIN,
    ST_DONE
  } state_t;

  localparam int STAMP_W = dsd_pkg::STAMP_W;
  localparam int WAY_W   = dsd_pkg::WAY_W;
  localparam int SET_W   = dsd_pkg::SET_W;

  logic [dsd_pkg::ROW_W-1:0] mem [dsd_pkg::SETS];
  logic [dsd_pkg::ROW_W-1:0] rd_data_r;

  state_t                    state_r, state_nxt;
  logic [SET_W-1:0]          clr_r, clr_nxt;
  dsd_pkg::item_t            cur_r;
  logic [dsd_pkg::SEL_W-1:0] sel_r, sel_nxt;
  logic [dsd_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [dsd_pkg::PERIOD_W-1:0] period_r;

  logic [STAMP_W-1:0] l1_val [dsd_pkg::L1_N];
  logic [WAY_W-1:0]   l1_idx [dsd_pkg::L1_N];
  logic [STAMP_W-1:0] l1_val_r [dsd_pkg::L1_N];
  logic [WAY_W-1:0]   l1_idx_r [dsd_pkg::L1_N];
  logic [STAMP_W-1:0] min_val, min_val_r;
  logic [WAY_W-1:0]   min_idx, min_idx_r;

  logic               out_free;
  logic               rd_en;
  logic               wr_en;
  logic [SET_W-1:0]   wr_addr;
  logic [dsd_pkg::ROW_W-1:0] wr_data;
  logic [STAMP_W-1:0] stamp;
  logic               do_write;
  logic               bip;
  logic [dsd_pkg::FILL_W-1:0] fill_inc;
  logic               out_valid_nxt;
  logic [WAY_W-1:0]   victim_nxt;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign rd_en     = (state_r == ST_IDLE) && q_valid;
  assign stat.pop      = rd_en;
  assign stat.clearing = (state_r == ST_CLEAR);

  // first min level: groups of ways, lowest way wins ties
  always_comb begin
    logic [STAMP_W-1:0] bv;
    logic [WAY_W-1:0]   bi;
    int                 w;
    for (int g = 0; g < dsd_pkg::L1_N; g++) begin
      bv = rd_data_r[g*dsd_pkg::L1_GRP*STAMP_W +: STAMP_W];
      bi = WAY_W'(g * dsd_pkg::L1_GRP);
      for (int k = 1; k < dsd_pkg::L1_GRP; k++) begin
        w = g * dsd_pkg::L1_GRP + k;
        if (w < dsd_pkg::WAYS) begin
          if (rd_data_r[w*STAMP_W +: STAMP_W] < bv) begin
            bv = rd_data_r[w*STAMP_W +: STAMP_W];
            bi = WAY_W'(w);
          end
        end
      end
      l1_val[g] = bv;
      l1_idx[g] = bi;
    end
  end

  always_comb begin
    min_val = l1_val_r[0];
    min_idx = l1_idx_r[0];
    for (int g = 1; g < dsd_pkg::L1_N; g++) begin
      if (l1_val_r[g] < min_val) begin
        min_val = l1_val_r[g];
        min_idx = l1_idx_r[g];
      end
    end
  end

  // completion of one beat: victim way, stamp, selector and fill count
  always_comb begin
    sel_nxt    = sel_r;
    fill_nxt   = fill_r;
    fill_inc   = fill_r + dsd_pkg::FILL_W'(1);
    stamp      = cur_r.now;
    do_write   = 1'b0;
    bip        = 1'b0;
    victim_nxt = '0;
    if (cur_r.req_type == dsd_pkg::REQ_VICTIM) begin
      victim_nxt = min_idx_r;
    end else if (cur_r.hit) begin
      do_write = 1'b1;
    end else begin
      do_write = 1'b1;
      case (cur_r.role)
        dsd_pkg::ROLE_LRU: begin
          if (sel_r < dsd_pkg::SEL_MAX) sel_nxt = sel_r + dsd_pkg::SEL_W'(1);
        end
        dsd_pkg::ROLE_BIP: begin
          bip = 1'b1;
          if (sel_r != '0) sel_nxt = sel_r - dsd_pkg::SEL_W'(1);
        end
        default: begin
          bip = (sel_r >= dsd_pkg::SEL_MID);
        end
      endcase
      if (bip) begin
        if (fill_inc >= period_r) begin
          fill_nxt = '0;
        end else begin
          fill_nxt = fill_inc;
          stamp    = (min_val_r != '0) ? min_val_r - STAMP_W'(1) : '0;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r.set_index;
    wr_data       = rd_data_r;
    wr_data[cur_r.way*STAMP_W +: STAMP_W] = stamp;
    out_valid_nxt = out_valid && out_stall;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + SET_W'(1);
        if (clr_r == SET_W'(dsd_pkg::SETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_MIN;
      ST_MIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          wr_en         = do_write;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      sel_r     <= dsd_pkg::SEL_MID;
      fill_r    <= '0;
      period_r  <= dsd_pkg::PERIOD_RST;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      out_valid <= out_valid_nxt;
      if (cfg_valid && cfg_ready) period_r <= cfg_bip_period;
      if (state_r == ST_DONE && out_free) begin
        sel_r              <= sel_nxt;
        fill_r             <= fill_nxt;
        out_victim_way     <= victim_nxt;
        out_selector_value <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= q_item;
    end
    if (state_r == ST_READ) begin
      l1_val_r <= l1_val;
      l1_idx_r <= l1_idx;
    end
    if (state_r == ST_MIN) begin
      min_val_r <= min_val;
      min_idx_r <= min_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[q_item.set_index];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dip_set_dueling_replacement.sv =====
`default_nettype none
// Set-dueling replacement state for a 2048-set, 16-way cache. Each request
// (victim lookup or update) gives exactly one result beat. After reset the
// timestamp memory is cleared one set row per cycle, with in_stall high;
// bip_period writes are taken at any time. A request then passes through
// the back end in order: queue pop and row read, two registered min-tree
// levels over the ways, and the write-back/result step, which waits while
// out_stall holds a result. A two-entry queue decouples intake from the back
// end, so up to two requests are taken while a result waits on out_stall.
module dip_set_dueling_replacement (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [dsd_pkg::SET_W-1:0]     in_set_index,
  input  wire logic [dsd_pkg::WAY_W-1:0]     in_way,
  input  wire logic                          in_hit,
  input  wire logic [dsd_pkg::STAMP_W-1:0]   in_now,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dsd_pkg::WAY_W-1:0]          out_victim_way,
  output logic [dsd_pkg::SEL_W-1:0]          out_selector_value,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dsd_pkg::PERIOD_W-1:0]  cfg_bip_period
);

  dsd_pkg::back_stat_t stat;
  logic                q_valid;
  dsd_pkg::item_t      q_item;

  dsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_set_index (in_set_index),
    .in_way       (in_way),
    .in_hit       (in_hit),
    .in_now       (in_now),
    .stat         (stat),
    .q_valid      (q_valid),
    .q_item       (q_item)
  );

  dsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_bip_period     (cfg_bip_period),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_victim_way     (out_victim_way),
    .out_selector_value (out_selector_value)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !(in_valid && !in_stall))
    else $error("input beat accepted during clear");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> (q_valid && !stat.clearing))
    else $error("pop from empty queue or during clear");

  a_no_pop_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |=> !stat.pop)
    else $error("back end popped while busy");

endmodule
`default_nettype wire
